// ----- rtl/pttb_pkg.sv -----
// Package: shared types, command codes and constants for the per-target backoff table.
`default_nettype none

package pttb_pkg;

	// Field widths
	localparam int CmdW     = 3;
	localparam int IdxW     = 6;
	localparam int CountW   = 16;
	localparam int InitW    = 16;
	localparam int BackoffW = 26;
	localparam int TimeW    = 32;
	localparam int ExpW     = 4;

	// Limits
	localparam int unsigned NumTargetsDefault = 64;
	localparam logic [ExpW-1:0]     ExpCap     = 4'd10;
	localparam logic [CountW-1:0]   CountMax   = 16'hFFFF;
	localparam logic [BackoffW-1:0] BackoffMax = 26'h3FF_FFFF;

	// Configuration register indexes
	localparam logic RegInitialBackoff = 1'b0;
	localparam logic RegMaxBackoff     = 1'b1;

	// Input commands
	typedef enum logic [CmdW-1:0] {
		CMD_QUERY   = 3'd0,
		CMD_FAILURE = 3'd1,
		CMD_SUCCESS = 3'd2,
		CMD_TICK    = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_t;

	// One stored table entry
	typedef struct packed {
		logic [CountW-1:0] failures;
		logic [TimeW-1:0]  deadline;
	} entry_t;

	// Query answer
	typedef struct packed {
		logic                skip;
		logic [CountW-1:0]   failure_count;
		logic [BackoffW-1:0] skip_remaining;
	} result_t;

	// Entry write-back request
	typedef struct packed {
		logic   wr_en;
		logic   set_valid;
		entry_t data;
	} update_t;

endpackage

`default_nettype wire

// ----- rtl/pttb_calc.sv -----
// Module: per-entry update and query evaluation for one transaction.
`default_nettype none

module pttb_calc (
	input  wire                                pttb_pkg::cmd_t cmd,
	input  wire logic                          idx_ok,
	input  wire logic                          entry_valid,
	input  wire pttb_pkg::entry_t              entry,
	input  wire logic [pttb_pkg::InitW-1:0]    initial_backoff,
	input  wire logic [pttb_pkg::BackoffW-1:0] max_backoff,
	input  wire logic [pttb_pkg::TimeW-1:0]    now_seconds,
	output pttb_pkg::result_t                  result,
	output pttb_pkg::update_t                  update
);

	logic [pttb_pkg::CountW-1:0]   cur_cnt;
	logic [pttb_pkg::TimeW-1:0]    cur_deadline;
	logic [pttb_pkg::CountW-1:0]   new_cnt;
	logic [pttb_pkg::CountW-1:0]   cnt_m1;
	logic [pttb_pkg::ExpW-1:0]     exp_sel;
	logic [pttb_pkg::BackoffW-1:0] shifted;
	logic [pttb_pkg::BackoffW-1:0] backoff;
	logic [pttb_pkg::TimeW-1:0]    diff;
	logic                          tracking;

	// Treat an empty entry as count zero, deadline zero
	assign cur_cnt      = entry_valid ? entry.failures : '0;
	assign cur_deadline = entry_valid ? entry.deadline : '0;
	assign tracking     = (initial_backoff != '0);

	// Saturating count and capped exponential interval
	assign new_cnt = (cur_cnt == pttb_pkg::CountMax) ? cur_cnt
		: cur_cnt + pttb_pkg::CountW'(1);
	assign cnt_m1  = new_cnt - pttb_pkg::CountW'(1);
	assign exp_sel = (cnt_m1 > pttb_pkg::CountW'(pttb_pkg::ExpCap)) ? pttb_pkg::ExpCap
		: cnt_m1[pttb_pkg::ExpW-1:0];
	assign shifted = pttb_pkg::BackoffW'(initial_backoff) << exp_sel;
	assign backoff = (shifted > max_backoff) ? max_backoff : shifted;

	// Modular distance to the deadline
	assign diff = cur_deadline - now_seconds;

	// Answer a query
	always_comb begin
		result = '0;
		if (idx_ok && entry_valid) begin
			result.failure_count = cur_cnt;
			if (tracking && cur_cnt != '0 && diff != '0 && !diff[pttb_pkg::TimeW-1]) begin
				result.skip           = 1'b1;
				result.skip_remaining = (diff[pttb_pkg::TimeW-1:pttb_pkg::BackoffW] != '0)
					? pttb_pkg::BackoffMax : diff[pttb_pkg::BackoffW-1:0];
			end
		end
	end

	// Build the write-back for failure and success
	always_comb begin
		update = '0;
		case (cmd)
			pttb_pkg::CMD_FAILURE: begin
				if (idx_ok && tracking) begin
					update.wr_en         = 1'b1;
					update.set_valid     = 1'b1;
					update.data.failures = new_cnt;
					update.data.deadline = now_seconds + pttb_pkg::TimeW'(backoff);
				end
			end
			pttb_pkg::CMD_SUCCESS: begin
				if (idx_ok && entry_valid && cur_cnt != '0) begin
					update.wr_en = 1'b1;
				end
			end
			default: begin
				update = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/per_target_backoff_table.sv -----
// Per-target capped exponential backoff table: keeps a failure count and a
// skip deadline for each target and answers skip queries against a seconds count.
//
// Channels: the input channel carries cmd and target_index under in_valid /
// in_stall; the output channel carries skip, failure_count and skip_remaining
// under out_valid / out_stall. Only a query produces an output transaction;
// failure, success, tick, clear and unknown commands produce none.
// Throughput: one input transaction per cycle while in_stall is low. The entry table is a memory
// with a registered read issued at accept; a write from the item in stage 1
// to the entry just read is forwarded, so back-to-back items on the same
// target need no bubble.
// Path: an accepted query goes through stage 1, then the output register.
// Stall: the output register holds its transaction while out_stall is high;
// a query waiting behind it stalls stage 1, which raises in_stall. Other
// commands keep flowing while the output waits.
// Reset: all entries read as empty through per-entry valid bits, the seconds
// count is zero, initial_backoff is zero (tracking off) and max_backoff is at
// its full value; no clearing pass is needed. A clear command drops every
// entry. The user must see that configuration through the APB port is written
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module per_target_backoff_table #(
	parameter int unsigned NUM_TARGETS = pttb_pkg::NumTargetsDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pttb_pkg::CmdW-1:0]     cmd,
	input  wire logic [pttb_pkg::IdxW-1:0]     target_index,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               skip,
	output logic [pttb_pkg::CountW-1:0]        failure_count,
	output logic [pttb_pkg::BackoffW-1:0]      skip_remaining
);

	// Only indexes reachable through target_index need storage
	localparam int unsigned IdxSpan    = 1 << pttb_pkg::IdxW;
	localparam int unsigned TableDepth = (NUM_TARGETS < IdxSpan) ? NUM_TARGETS : IdxSpan;
	localparam int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;

	// Configuration registers
	logic [pttb_pkg::InitW-1:0]    initial_backoff_q;
	logic [pttb_pkg::BackoffW-1:0] max_backoff_q;
	logic                          cfg_wr;

	// Table storage
	pttb_pkg::entry_t              mem [TableDepth];
	logic [TableDepth-1:0]         valid_q;
	logic [pttb_pkg::TimeW-1:0]    now_q;

	// Stage 1
	logic                          valid_s1;
	logic [pttb_pkg::CmdW-1:0]     cmd_s1;
	logic [pttb_pkg::IdxW-1:0]     idx_s1;
	pttb_pkg::entry_t              rd_s1;
	logic                          byp_s1;
	pttb_pkg::entry_t              byp_data_s1;

	// Output register
	logic                          out_valid_q;
	pttb_pkg::result_t             out_q;

	logic                          in_acc;
	logic                          adv;
	logic                          is_query;
	logic                          idx_ok;
	logic                          entry_valid;
	logic [AddrW-1:0]              addr_s1;
	logic [AddrW-1:0]              rd_addr;
	pttb_pkg::cmd_t                cmd_e;
	pttb_pkg::entry_t              entry;
	pttb_pkg::result_t             result;
	pttb_pkg::update_t             update;
	logic                          wr_commit;

	// APB: always ready, decode by word address
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		if (paddr[2] == pttb_pkg::RegMaxBackoff) begin
			prdata = 32'(max_backoff_q);
		end else begin
			prdata = 32'(initial_backoff_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_backoff_q <= '0;
			max_backoff_q     <= pttb_pkg::BackoffMax;
		end else if (cfg_wr) begin
			if (paddr[2] == pttb_pkg::RegInitialBackoff) begin
				initial_backoff_q <= pwdata[pttb_pkg::InitW-1:0];
			end else begin
				max_backoff_q <= pwdata[pttb_pkg::BackoffW-1:0];
			end
		end
	end

	// Decode stage 1
	assign cmd_e       = pttb_pkg::cmd_t'(cmd_s1);
	assign is_query    = (cmd_e == pttb_pkg::CMD_QUERY);
	assign idx_ok      = (32'(idx_s1) < 32'(NUM_TARGETS));
	assign addr_s1     = idx_s1[AddrW-1:0];
	assign entry_valid = idx_ok && valid_q[addr_s1];
	assign entry       = byp_s1 ? byp_data_s1 : rd_s1;

	// Advance stage 1 unless a query is blocked by a held output
	assign adv       = valid_s1 && !(is_query && out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign wr_commit = adv && update.wr_en;
	assign rd_addr   = target_index[AddrW-1:0];

	pttb_calc u_calc (
		.cmd             (cmd_e),
		.idx_ok          (idx_ok),
		.entry_valid     (entry_valid),
		.entry           (entry),
		.initial_backoff (initial_backoff_q),
		.max_backoff     (max_backoff_q),
		.now_seconds     (now_q),
		.result          (result),
		.update          (update)
	);

	// Entry memory: write back from stage 1, read at accept
	always_ff @(posedge clk) begin
		if (wr_commit) begin
			mem[addr_s1] <= update.data;
		end
		if (in_acc) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// Forward a same-entry write to the transaction being accepted
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byp_data_s1 <= update.data;
		end
	end

	// Stage 1 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
			cmd_s1   <= '0;
			idx_s1   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= cmd;
				idx_s1   <= target_index;
				byp_s1   <= wr_commit && (addr_s1 == rd_addr);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Valid bits and seconds count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q   <= '0;
		end else if (adv) begin
			case (cmd_e)
				pttb_pkg::CMD_TICK: begin
					now_q <= now_q + pttb_pkg::TimeW'(1);
				end
				pttb_pkg::CMD_CLEAR: begin
					valid_q <= '0;
				end
				pttb_pkg::CMD_FAILURE: begin
					if (update.set_valid) begin
						valid_q[addr_s1] <= 1'b1;
					end
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// Output register: load on an advancing query, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_query) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_query) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign skip           = out_q.skip;
	assign failure_count  = out_q.failure_count;
	assign skip_remaining = out_q.skip_remaining;

endmodule

`default_nettype wire
